// ----- hw/rtl/mrc_pkg.sv -----
// Shared types, constants and the CRC-16 byte update for the Modbus RTU
// response checker. No dependencies.
`default_nettype none

package mrc_pkg;

  localparam int unsigned FRAME_LEN     = 8;
  localparam int unsigned TICK_BITS_DEF = 16;
  localparam int unsigned ADDR_W        = 8;
  localparam int unsigned TIMEOUT_W     = 16;
  localparam int unsigned CFG_DATA_W    = 16;
  localparam int unsigned HEAD_W        = 48;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [ADDR_W-1:0]    ADDR_RST    = 8'd1;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd50;

  typedef enum logic [0:0] {
    REG_EXP_ADDR = 1'b0,
    REG_TIMEOUT  = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic              status;
    logic [HEAD_W-1:0] frame_head;
    logic [15:0]       frame_crc;
  } result_t;

  // Reflected CRC-16 update over one byte, LSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mrc_in_stage.sv -----
// Input register of the response checker: holds one accepted item.
// Depends on mrc_pkg.
`default_nettype none

module mrc_in_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [1:0]    opcode_i,
  input  wire logic [7:0]    rx_byte_i,
  input  wire logic          take_i,
  output logic               item_valid_o,
  output mrc_pkg::item_t     item_o
);
  import mrc_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  assign in_ready_o   = !valid_q || take_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_comb begin
    valid_d = valid_q;
    if (take_i) begin
      valid_d = 1'b0;
    end
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.opcode  <= opcode_i;
      item_q.rx_byte <= rx_byte_i;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mrc_engine.sv -----
// Frame state of the response checker: byte collection, running CRC,
// tick counter and the match / timeout decision. Depends on mrc_pkg.
`default_nettype none

module mrc_engine #(
  parameter int unsigned TICK_BITS = mrc_pkg::TICK_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             item_valid_i,
  input  wire mrc_pkg::item_t                   item_i,
  input  wire logic [mrc_pkg::ADDR_W-1:0]       exp_addr_i,
  input  wire logic [mrc_pkg::TIMEOUT_W-1:0]    timeout_i,
  output logic                                  res_valid_o,
  output mrc_pkg::result_t                      res_o
);
  import mrc_pkg::*;

  localparam int unsigned CW = (TICK_BITS > TIMEOUT_W) ? TICK_BITS : TIMEOUT_W;
  localparam logic [2:0] LAST_IDX = 3'(FRAME_LEN - 1);
  localparam logic [2:0] CRC_END  = 3'(FRAME_LEN - 2);
  localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

  logic                 armed_q, armed_d;
  logic [2:0]           idx_q, idx_d;
  logic [15:0]          crc_q, crc_d;
  logic [TICK_BITS-1:0] ticks_q, ticks_d;
  logic [7:0]           store_q [FRAME_LEN-1];
  logic                 store_we;

  logic [TICK_BITS-1:0] tick_next;
  logic [15:0]          rx_crc;
  logic                 frame_ok;
  logic                 timed_out;

  assign tick_next = (ticks_q == TICK_MAX) ? ticks_q : ticks_q + 1'b1;
  assign timed_out = (CW'(tick_next) >= CW'(timeout_i)) || (tick_next == TICK_MAX);
  assign rx_crc    = {item_i.rx_byte, store_q[6]};
  assign frame_ok  = (rx_crc == crc_q) && (store_q[0] == exp_addr_i);

  always_comb begin
    armed_d     = armed_q;
    idx_d       = idx_q;
    crc_d       = crc_q;
    ticks_d     = ticks_q;
    store_we    = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (item_valid_i) begin
      case (item_i.opcode)
        OP_START: begin
          armed_d = 1'b1;
          idx_d   = '0;
          crc_d   = CRC_INIT;
          ticks_d = '0;
        end
        OP_BYTE: begin
          if (armed_q) begin
            if (idx_q < LAST_IDX) begin
              store_we = 1'b1;
              if (idx_q < CRC_END) begin
                crc_d = crc_byte(crc_q, item_i.rx_byte);
              end
              idx_d = idx_q + 1'b1;
            end else begin
              idx_d = '0;
              crc_d = CRC_INIT;
              if (frame_ok) begin
                res_valid_o      = 1'b1;
                res_o.status     = 1'b0;
                res_o.frame_head = {store_q[0], store_q[1], store_q[2],
                                    store_q[3], store_q[4], store_q[5]};
                res_o.frame_crc  = rx_crc;
                armed_d          = 1'b0;
              end
            end
          end
        end
        OP_TICK: begin
          if (armed_q) begin
            ticks_d = tick_next;
            if (timed_out) begin
              res_valid_o  = 1'b1;
              res_o.status = 1'b1;
              armed_d      = 1'b0;
              idx_d        = '0;
              crc_d        = CRC_INIT;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      idx_q   <= '0;
      crc_q   <= CRC_INIT;
      ticks_q <= '0;
    end else begin
      armed_q <= armed_d;
      idx_q   <= idx_d;
      crc_q   <= crc_d;
      ticks_q <= ticks_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[idx_q] <= item_i.rx_byte;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/modbus_rtu_response_checker_top.sv -----
// Top level of the Modbus RTU response checker: configuration registers,
// result register and wiring. Depends on mrc_pkg, mrc_in_stage, mrc_engine.
//
//   port group      dir   handshake                payload
//   input item      in    in_valid_i / in_ready_o  opcode_i, rx_byte_i
//   result item     out   out_valid_o / out_ready_i status_o, frame_head_o,
//                                                  frame_crc_o
//   configuration   in    cfg_we_i                 cfg_idx_i, cfg_data_i
//
// An item is registered on accept and processed when the engine takes it (a held
// result stalls this); its result (if any) is then registered in the output register.
// One item per cycle is sustained while the output register drains.
// A held result stalls processing only; the input register still takes one
// item. Reset clears control state; frame bytes are not reset.
`default_nettype none

module modbus_rtu_response_checker_top #(
  parameter int unsigned TICK_BITS = mrc_pkg::TICK_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [1:0]                        opcode_i,
  input  wire logic [7:0]                        rx_byte_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic                                   status_o,
  output logic [mrc_pkg::HEAD_W-1:0]             frame_head_o,
  output logic [15:0]                            frame_crc_o,
  input  wire logic                              cfg_we_i,
  input  wire logic                              cfg_idx_i,
  input  wire logic [mrc_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import mrc_pkg::*;

  logic [ADDR_W-1:0]    exp_addr_q;
  logic [TIMEOUT_W-1:0] timeout_q;

  logic    item_valid;
  item_t   item;
  logic    take;
  logic    res_valid;
  result_t res;
  logic    out_valid_q;
  result_t out_q;

  assign take = item_valid && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_addr_q <= ADDR_RST;
      timeout_q  <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_EXP_ADDR: exp_addr_q <= cfg_data_i[ADDR_W-1:0];
        REG_TIMEOUT:  timeout_q  <= cfg_data_i[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  mrc_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .rx_byte_i    (rx_byte_i),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  mrc_engine #(
    .TICK_BITS (TICK_BITS)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (take),
    .item_i       (item),
    .exp_addr_i   (exp_addr_q),
    .timeout_i    (timeout_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= res_valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_q.status;
  assign frame_head_o = out_q.frame_head;
  assign frame_crc_o  = out_q.frame_crc;

endmodule

`default_nettype wire
